>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros
// Assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define M3I_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, checked out of reset.
`define M3I_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

>>> rtl/m3i_pkg.sv
// ---------------------------------------------------------------------------
// m3i_pkg
// Widths, types and constants of the 3x3 matrix inverse pipeline.
// ---------------------------------------------------------------------------
package m3i_pkg;

	localparam int FRAC_BITS = 16;             // fraction bits of the entries
	localparam int AW        = 32;             // entry / result width
	localparam int PW        = 2 * AW;         // entry product
	localparam int CW        = PW + 1;         // cofactor, signed
	localparam int DW        = 98;             // determinant, signed
	localparam int QB        = AW;             // quotient bits resolved
	localparam int NW_A      = PW + 2 * FRAC_BITS + 1;
	localparam int NW_B      = DW - 1;
	localparam int NW        = ((NW_A > NW_B) ? NW_A : NW_B) + 1; // dividend
	localparam int VW        = NW + QB;        // divider compare width
	localparam int LANE_LAT  = QB + 2;         // divider lane registers
	localparam int LATENCY   = LANE_LAT + 8;   // accept edge to result edge

	localparam logic [AW-1:0] SAT_MAX = {1'b0, {(AW-1){1'b1}}};
	localparam logic [AW-1:0] SAT_MIN = {1'b1, {(AW-1){1'b0}}};

	typedef logic signed [AW-1:0] ent_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [CW-1:0] cof_t;
	typedef logic signed [DW-1:0] det_t;
	typedef logic [PW-1:0]        mag_t;
	typedef logic [NW-1:0]        num_t;
	typedef logic [DW-1:0]        den_t;

	typedef struct packed {
		logic            sing;
		logic            dov;
		logic [AW-1:0]   detv;
	} side_t;

endpackage

>>> rtl/m3i_cofactor.sv
// ---------------------------------------------------------------------------
// m3i_cofactor
// Two stages: entry products, then the nine adjugate entries.
// ---------------------------------------------------------------------------
module m3i_cofactor (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vin,
	input  m3i_pkg::ent_t   ent [9],
	output logic            vld_s2,
	output m3i_pkg::cof_t   adj_s2 [9],
	output m3i_pkg::ent_t   a0_s2 [3]
);
	localparam int CW = m3i_pkg::CW;

	logic          vld_s1;
	m3i_pkg::prod_t pa_s1 [9];
	m3i_pkg::prod_t pb_s1 [9];
	m3i_pkg::ent_t  a0_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vin;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar r = 0; r < 3; r++) begin : g_row
		for (genvar c = 0; c < 3; c++) begin : g_col
			localparam int K  = r * 3 + c;
			localparam int C1 = (c + 1) % 3;
			localparam int C2 = (c + 2) % 3;
			localparam int R1 = (r + 1) % 3;
			localparam int R2 = (r + 2) % 3;
			always_ff @(posedge clk) begin
				pa_s1[K]  <= ent[C1*3+R1] * ent[C2*3+R2];
				pb_s1[K]  <= ent[C1*3+R2] * ent[C2*3+R1];
				adj_s2[K] <= CW'(pa_s1[K]) - CW'(pb_s1[K]);
			end
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_a0
		always_ff @(posedge clk) begin
			a0_s1[c] <= ent[c];
			a0_s2[c] <= a0_s1[c];
		end
	end

endmodule

>>> rtl/m3i_det.sv
// ---------------------------------------------------------------------------
// m3i_det
// Determinant along row 0: split 32x65 products, terms, then the sum.
// ---------------------------------------------------------------------------
module m3i_det (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vin,
	input  m3i_pkg::cof_t   adj [9],
	input  m3i_pkg::ent_t   a0 [3],
	output logic            vld_s5,
	output m3i_pkg::cof_t   adj_s5 [9],
	output m3i_pkg::det_t   det_s5
);
	localparam int CW = m3i_pkg::CW;
	localparam int DW = m3i_pkg::DW;
	localparam int HW = CW - 32;

	logic vld_s3, vld_s4;
	logic signed [32+HW-1:0] pl_s3 [3];
	logic signed [32+HW-1:0] ph_s3 [3];
	m3i_pkg::det_t term_s4 [3];
	m3i_pkg::cof_t adj_s3 [9];
	m3i_pkg::cof_t adj_s4 [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s3 <= vin;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_term
		always_ff @(posedge clk) begin
			// low half of the cofactor is unsigned, high half carries the sign
			pl_s3[c]   <= a0[c] * $signed({1'b0, adj[c*3][31:0]});
			ph_s3[c]   <= a0[c] * $signed(adj[c*3][CW-1:32]);
			term_s4[c] <= (DW'(ph_s3[c]) <<< 32) + DW'(pl_s3[c]);
		end
	end

	always_ff @(posedge clk) begin
		det_s5 <= term_s4[0] + term_s4[1] + term_s4[2];
		adj_s3 <= adj;
		adj_s4 <= adj_s3;
		adj_s5 <= adj_s4;
	end

endmodule

>>> rtl/m3i_prep.sv
// ---------------------------------------------------------------------------
// m3i_prep
// Magnitudes and signs, then dividends, divisor and the rounded determinant.
// ---------------------------------------------------------------------------
module m3i_prep (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            vin,
	input  m3i_pkg::cof_t   adj [9],
	input  m3i_pkg::det_t   det,
	output logic            vld_s7,
	output m3i_pkg::num_t   num_s7 [9],
	output m3i_pkg::den_t   den_s7,
	output logic            neg_s7 [9],
	output m3i_pkg::side_t  side_s7
);
	localparam int FB = m3i_pkg::FRAC_BITS;
	localparam int AW = m3i_pkg::AW;
	localparam int PW = m3i_pkg::PW;
	localparam int CW = m3i_pkg::CW;
	localparam int DW = m3i_pkg::DW;
	localparam int NW = m3i_pkg::NW;
	localparam int MW = DW - 1;

	logic            vld_s6;
	logic [MW-1:0]   dmag_s6;
	logic            dneg_s6;
	logic            sing_s6;
	m3i_pkg::mag_t   amag_s6 [9];
	logic            aneg_s6 [9];

	logic [DW-1:0]   rnd;
	logic [DW-1:0]   dq;
	logic [AW-1:0]   detv;
	logic            dov;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			vld_s6 <= vin;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		dneg_s6 <= det[DW-1];
		dmag_s6 <= MW'(det[DW-1] ? -det : det);
		sing_s6 <= (det == '0);
	end

	for (genvar k = 0; k < 9; k++) begin : g_lane
		always_ff @(posedge clk) begin
			aneg_s6[k] <= adj[k][CW-1];
			amag_s6[k] <= PW'(adj[k][CW-1] ? -adj[k] : adj[k]);
			// 2*|adj|*2^(2F) + |D|: the half-divisor term rounds to nearest
			num_s7[k]  <= (NW'(amag_s6[k]) << (2 * FB + 1)) + NW'(dmag_s6);
			neg_s7[k]  <= aneg_s6[k] ^ dneg_s6;
		end
	end

	always_comb begin
		rnd  = DW'(dmag_s6) + (DW'(1) << (2 * FB - 1));
		dq   = rnd >> (2 * FB);
		dov  = 1'b0;
		detv = dq[AW-1:0];
		if (dneg_s6) begin
			if (dq > DW'(m3i_pkg::SAT_MIN)) begin
				dov  = 1'b1;
				detv = m3i_pkg::SAT_MIN;
			end else begin
				detv = '0 - dq[AW-1:0];
			end
		end else if (dq > DW'(m3i_pkg::SAT_MAX)) begin
			dov  = 1'b1;
			detv = m3i_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		den_s7       <= DW'(dmag_s6) << 1;
		side_s7.sing <= sing_s6;
		side_s7.dov  <= dov;
		side_s7.detv <= detv;
	end

endmodule

>>> rtl/m3i_div_lane.sv
// ---------------------------------------------------------------------------
// m3i_div_lane
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ---------------------------------------------------------------------------
module m3i_div_lane (
	input  logic                        clk,
	input  m3i_pkg::num_t               num,
	input  m3i_pkg::den_t               den,
	input  logic                        neg,
	output logic [m3i_pkg::AW-1:0]      res_q,
	output logic                        ovf_q
);
	localparam int QB = m3i_pkg::QB;
	localparam int NW = m3i_pkg::NW;
	localparam int VW = m3i_pkg::VW;

	m3i_pkg::num_t rem_sk [QB+1];
	m3i_pkg::den_t den_sk [QB+1];
	logic [QB-1:0] quo_sk [QB+1];
	logic          big_sk [QB+1];
	logic          neg_sk [QB+1];

	logic [QB-1:0] quo;
	logic [QB-1:0] res_d;
	logic          ovf_d;

	// quotient of 2^QB or more can only saturate
	always_ff @(posedge clk) begin
		rem_sk[0] <= num;
		den_sk[0] <= den;
		quo_sk[0] <= '0;
		big_sk[0] <= (VW'(num) >= (VW'(den) << QB));
		neg_sk[0] <= neg;
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		localparam int SH = QB - k;
		logic ge;
		assign ge = (VW'(rem_sk[k-1]) >= (VW'(den_sk[k-1]) << SH));
		always_ff @(posedge clk) begin
			rem_sk[k] <= ge ? rem_sk[k-1] - NW'(VW'(den_sk[k-1]) << SH) : rem_sk[k-1];
			den_sk[k] <= den_sk[k-1];
			quo_sk[k] <= {quo_sk[k-1][QB-2:0], ge};
			big_sk[k] <= big_sk[k-1];
			neg_sk[k] <= neg_sk[k-1];
		end
	end

	always_comb begin
		quo   = quo_sk[QB];
		ovf_d = 1'b0;
		res_d = quo;
		if (big_sk[QB]) begin
			ovf_d = 1'b1;
			res_d = neg_sk[QB] ? m3i_pkg::SAT_MIN : m3i_pkg::SAT_MAX;
		end else if (neg_sk[QB] && (quo != '0)) begin
			if (quo > m3i_pkg::SAT_MIN) begin
				ovf_d = 1'b1;
				res_d = m3i_pkg::SAT_MIN;
			end else begin
				res_d = '0 - quo;
			end
		end else if (quo > m3i_pkg::SAT_MAX) begin
			ovf_d = 1'b1;
			res_d = m3i_pkg::SAT_MAX;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		ovf_q <= ovf_d;
	end

endmodule

>>> rtl/matrix3x3_inverse_unit.sv
// ---------------------------------------------------------------------------
// matrix3x3_inverse_unit
// Q16.16 3x3 matrix inverse by adjugate over determinant, fully pipelined.
// ---------------------------------------------------------------------------
// One matrix is taken on every clock edge with start high; busy never rises.
// Each item comes back on done after passing through two stages
// of products and cofactors, three of determinant, two of operand set-up,
// then nine parallel divider lanes of one quotient bit per stage (32 stages
// plus an entry and a saturation register) and an output register. Results
// stand for one cycle only, so the receiver must take them as they come.
`include "assert_macros.svh"

module matrix3x3_inverse_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [31:0]  col0_x,
	input  logic signed [31:0]  col0_y,
	input  logic signed [31:0]  col0_z,
	input  logic signed [31:0]  col1_x,
	input  logic signed [31:0]  col1_y,
	input  logic signed [31:0]  col1_z,
	input  logic signed [31:0]  col2_x,
	input  logic signed [31:0]  col2_y,
	input  logic signed [31:0]  col2_z,
	output logic                done,
	output logic signed [31:0]  inv00,
	output logic signed [31:0]  inv01,
	output logic signed [31:0]  inv02,
	output logic signed [31:0]  inv10,
	output logic signed [31:0]  inv11,
	output logic signed [31:0]  inv12,
	output logic signed [31:0]  inv20,
	output logic signed [31:0]  inv21,
	output logic signed [31:0]  inv22,
	output logic signed [31:0]  det_value,
	output logic                singular,
	output logic                overflow
);
	localparam int AW  = m3i_pkg::AW;
	localparam int LAT = m3i_pkg::LANE_LAT;

	logic               vin;
	m3i_pkg::ent_t      ent [9];

	logic               vld_s2;
	m3i_pkg::cof_t      adj_s2 [9];
	m3i_pkg::ent_t      a0_s2 [3];

	logic               vld_s5;
	m3i_pkg::cof_t      adj_s5 [9];
	m3i_pkg::det_t      det_s5;

	logic               vld_s7;
	m3i_pkg::num_t      num_s7 [9];
	m3i_pkg::den_t      den_s7;
	logic               neg_s7 [9];
	m3i_pkg::side_t     side_s7;

	logic [AW-1:0]      lres [9];
	logic               lovf [9];

	logic               vld_q  [LAT];
	m3i_pkg::side_t     side_q [LAT];

	logic               done_q;
	logic [AW-1:0]      inv_q [9];
	logic [AW-1:0]      detv_q;
	logic               sing_q;
	logic               ovf_q;
	logic               any_ovf;

	assign busy = 1'b0;
	assign vin  = start & ~busy;

	// row-major entry order
	assign ent[0] = col0_x;
	assign ent[1] = col1_x;
	assign ent[2] = col2_x;
	assign ent[3] = col0_y;
	assign ent[4] = col1_y;
	assign ent[5] = col2_y;
	assign ent[6] = col0_z;
	assign ent[7] = col1_z;
	assign ent[8] = col2_z;

	m3i_cofactor u_cof (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (vin),
		.ent    (ent),
		.vld_s2 (vld_s2),
		.adj_s2 (adj_s2),
		.a0_s2  (a0_s2)
	);

	m3i_det u_det (
		.clk    (clk),
		.arst_n (arst_n),
		.vin    (vld_s2),
		.adj    (adj_s2),
		.a0     (a0_s2),
		.vld_s5 (vld_s5),
		.adj_s5 (adj_s5),
		.det_s5 (det_s5)
	);

	m3i_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.vin     (vld_s5),
		.adj     (adj_s5),
		.det     (det_s5),
		.vld_s7  (vld_s7),
		.num_s7  (num_s7),
		.den_s7  (den_s7),
		.neg_s7  (neg_s7),
		.side_s7 (side_s7)
	);

	for (genvar k = 0; k < 9; k++) begin : g_lane
		m3i_div_lane u_lane (
			.clk   (clk),
			.num   (num_s7[k]),
			.den   (den_s7),
			.neg   (neg_s7[k]),
			.res_q (lres[k]),
			.ovf_q (lovf[k])
		);
	end

	// side band runs alongside the divider lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else begin
			vld_q[0] <= vld_s7;
			for (int i = 1; i < LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_s7;
		for (int i = 1; i < LAT; i++) begin
			side_q[i] <= side_q[i-1];
		end
	end

	always_comb begin
		any_ovf = side_q[LAT-1].dov;
		for (int k = 0; k < 9; k++) begin
			any_ovf = any_ovf | lovf[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_q[LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		sing_q <= side_q[LAT-1].sing;
		if (side_q[LAT-1].sing) begin
			for (int k = 0; k < 9; k++) begin
				inv_q[k] <= '0;
			end
			detv_q <= '0;
			ovf_q  <= 1'b0;
		end else begin
			for (int k = 0; k < 9; k++) begin
				inv_q[k] <= lres[k];
			end
			detv_q <= side_q[LAT-1].detv;
			ovf_q  <= any_ovf;
		end
	end

	assign done      = done_q;
	assign inv00     = inv_q[0];
	assign inv01     = inv_q[1];
	assign inv02     = inv_q[2];
	assign inv10     = inv_q[3];
	assign inv11     = inv_q[4];
	assign inv12     = inv_q[5];
	assign inv20     = inv_q[6];
	assign inv21     = inv_q[7];
	assign inv22     = inv_q[8];
	assign det_value = detv_q;
	assign singular  = sing_q;
	assign overflow  = ovf_q;

	`M3I_ASSERT_IMP(a_latency, clk, arst_n, done, $past(start && !busy, m3i_pkg::LATENCY))
	`M3I_ASSERT_IMP(a_singular, clk, arst_n, done && singular, !overflow && det_value == '0 && inv11 == '0)
	`M3I_ASSERT_NXT(a_lane_out, clk, arst_n, vld_q[LAT-1], done)

endmodule
